/* rtl/pta_pkg.sv */
// Shared types, codes and constant tables of the pixel-to-glyph renderer.
// No dependencies; every other file but pta_stream_if imports this package.
package pta_pkg;

    localparam int CFG_DATA_W        = 13;
    localparam int CFG_IDX_W         = 3;
    localparam int MAX_DIMENSION_DEF = 4096;
    localparam int GLYPH_LEVELS      = 70;

    // Register reset values
    localparam logic [1:0]            RST_COLOR_MODE   = 2'd0;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 13'd80;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 13'd24;
    localparam logic [CFG_DATA_W-1:0] RST_VIS_COLS     = 13'd80;
    localparam logic [CFG_DATA_W-1:0] RST_VIS_ROWS     = 13'd24;

    // Luminance: sum / 1000 as multiply by ceil(2^28 / 1000), exact for sums up to 255000
    localparam int              SUM_W      = 18;
    localparam int              LUM_SHIFT  = 28;
    localparam logic [18:0]     LUM_RECIP  = 19'd268436;
    localparam logic [SUM_W-1:0] W_RED     = 18'd299;
    localparam logic [SUM_W-1:0] W_GREEN   = 18'd587;
    localparam logic [SUM_W-1:0] W_BLUE    = 18'd114;

    // Cube step: x / 51 as (x * 1286) >> 16, exact for 8-bit x
    localparam logic [18:0] CUBE_RECIP = 19'd1286;
    localparam int          CUBE_BASE  = 16;

    // SGR foreground codes
    localparam logic [7:0] SGR_BLACK    = 8'd30;
    localparam logic [7:0] SGR_RED      = 8'd31;
    localparam logic [7:0] SGR_GREEN    = 8'd32;
    localparam logic [7:0] SGR_BLUE     = 8'd34;
    localparam logic [7:0] SGR_WHITE    = 8'd37;
    localparam logic [7:0] SGR_BR_RED   = 8'd91;
    localparam logic [7:0] SGR_BR_GREEN = 8'd92;
    localparam logic [7:0] SGR_BR_BLUE  = 8'd94;
    localparam logic [7:0] DARK_LIMIT   = 8'd32;
    localparam logic [7:0] BRIGHT_LIMIT = 8'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLOR_MODE   = 3'd0,
        REG_FRAME_WIDTH  = 3'd1,
        REG_FRAME_HEIGHT = 3'd2,
        REG_VIS_COLS     = 3'd3,
        REG_VIS_ROWS     = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_HOME    = 2'd0,
        KIND_GLYPH   = 2'd1,
        KIND_NEWLINE = 2'd2,
        KIND_RESET   = 2'd3
    } t_kind;

    // Colour commands; the colour mode register uses the same codes
    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_ANSI    = 2'd1,
        CMD_PALETTE = 2'd2,
        CMD_TRUE    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [31:0] pixel_word;
    } t_pixel_in;

    typedef struct packed {
        logic [1:0] item_kind;
        logic [6:0] glyph;
        logic [1:0] color_command;
        logic [7:0] palette_code;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       run_last;
    } t_glyph_out;

    // Per-pixel control decided at acceptance
    typedef struct packed {
        logic       home;
        logic       glyph_en;
        logic       newline;
        logic       frame_end;
        t_cmd       cmd;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_stage;

    // Everything one pixel can emit
    typedef struct packed {
        logic       home;
        logic       glyph_en;
        logic       newline;
        logic       frame_end;
        logic [6:0] glyph;
        t_cmd       cmd;
        logic [7:0] code;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_res_set;

    localparam int RAMP_LEN = 69;
    localparam logic [8*RAMP_LEN-1:0] RAMP =
        " .'\140^\",:;Il!i><~+_-?][}{1)(|/tfjrxnuvczXYUJCLQ0OZmwqpdbkhao*#MW&8%B@$";

    typedef logic [255:0][6:0] t_glyph_tab;

    function automatic t_glyph_tab build_glyph_tab();
        t_glyph_tab tab;
        int         idx;
        for (int i = 0; i < 256; i++) begin
            idx = (i * (GLYPH_LEVELS - 1)) / 255;
            if (idx >= RAMP_LEN) begin
                idx = RAMP_LEN - 1;
            end
            tab[8'(i)] = RAMP[8*(RAMP_LEN-1-idx) +: 7];
        end
        return tab;
    endfunction

    localparam t_glyph_tab GLYPH_TAB = build_glyph_tab();

endpackage

/* rtl/pta_stream_if.sv */
// Valid/ready stream channel carrying one payload beat of type T.
// Payload types come from pta_pkg.
interface pta_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/pta_track.sv */
// Frame position tracking and truecolour history, updated per accepted pixel.
// Depends on pta_pkg.
module pta_track #(
    parameter int MAX_DIMENSION = pta_pkg::MAX_DIMENSION_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [23:0]                     i_rgb,
    input  logic [1:0]                      i_mode,
    input  logic [pta_pkg::CFG_DATA_W-1:0]  i_frame_width,
    input  logic [pta_pkg::CFG_DATA_W-1:0]  i_frame_height,
    input  logic [pta_pkg::CFG_DATA_W-1:0]  i_vis_cols,
    input  logic [pta_pkg::CFG_DATA_W-1:0]  i_vis_rows,
    output pta_pkg::t_stage                 o_ctl
);
    import pta_pkg::*;

    localparam int CW = $clog2(MAX_DIMENSION);

    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic [23:0]   r_prev_rgb, n_prev_rgb;
    logic          r_prev_valid, n_prev_valid;

    logic [CW-1:0] w_wm1, w_hm1, w_col, w_row;
    logic          w_home, w_row_vis, w_glyph_en, w_eol, w_eof, w_pv, w_true_emit;
    t_cmd          w_cmd;

    // Last column / row index of the effective frame
    always_comb begin
        if (i_frame_width == '0) begin
            w_wm1 = '0;
        end else if (32'(i_frame_width) > MAX_DIMENSION) begin
            w_wm1 = CW'(MAX_DIMENSION - 1);
        end else begin
            w_wm1 = CW'(i_frame_width - 13'd1);
        end
        if (i_frame_height == '0) begin
            w_hm1 = '0;
        end else if (32'(i_frame_height) > MAX_DIMENSION) begin
            w_hm1 = CW'(MAX_DIMENSION - 1);
        end else begin
            w_hm1 = CW'(i_frame_height - 13'd1);
        end
    end

    always_comb begin
        w_col       = (r_col > w_wm1) ? w_wm1 : r_col;
        w_row       = (r_row > w_hm1) ? w_hm1 : r_row;
        w_home      = (w_col == '0) && (w_row == '0);
        w_row_vis   = 32'(w_row) < 32'(i_vis_rows);
        w_glyph_en  = w_row_vis && (32'(w_col) < 32'(i_vis_cols));
        w_eol       = (w_col == w_wm1);
        w_eof       = w_eol && (w_row == w_hm1);
        w_pv        = w_home ? 1'b0 : r_prev_valid;
        w_true_emit = !w_pv || (r_prev_rgb != i_rgb);

        case (i_mode)
            CMD_ANSI:    w_cmd = CMD_ANSI;
            CMD_PALETTE: w_cmd = CMD_PALETTE;
            CMD_TRUE:    w_cmd = w_true_emit ? CMD_TRUE : CMD_NONE;
            default:     w_cmd = CMD_NONE;
        endcase
    end

    always_comb begin
        o_ctl.home      = w_home;
        o_ctl.glyph_en  = w_glyph_en;
        o_ctl.newline   = w_eol && w_row_vis;
        o_ctl.frame_end = w_eof;
        o_ctl.cmd       = w_cmd;
        o_ctl.red       = i_rgb[7:0];
        o_ctl.green     = i_rgb[15:8];
        o_ctl.blue      = i_rgb[23:16];
    end

    // Advance position; update colour history on an emitted truecolour command, and drop it at frame home
    always_comb begin
        n_col        = r_col;
        n_row        = r_row;
        n_prev_rgb   = r_prev_rgb;
        n_prev_valid = r_prev_valid;
        if (i_accept) begin
            if (w_eol) begin
                n_col = '0;
                n_row = w_eof ? '0 : w_row + CW'(1);
            end else begin
                n_col = w_col + CW'(1);
                n_row = w_row;
            end
            n_prev_valid = w_pv;
            if (w_glyph_en && (w_cmd == CMD_TRUE)) begin
                n_prev_rgb   = i_rgb;
                n_prev_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_prev_rgb   <= '0;
            r_prev_valid <= 1'b0;
        end else begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_prev_rgb   <= n_prev_rgb;
            r_prev_valid <= n_prev_valid;
        end
    end

endmodule

/* rtl/pta_lum.sv */
// Three-stage luminance pipeline: capture, weighted sum, scale by 1/1000; glyph and colour code follow.
// Depends on pta_pkg.
module pta_lum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pta_pkg::t_stage   i_ctl,
    output logic              o_valid,
    input  logic              i_ready,
    output pta_pkg::t_res_set o_set
);
    import pta_pkg::*;

    t_stage           r_s1, r_s2, r_s3;
    logic             r_v1, r_v2, r_v3;
    logic [SUM_W-1:0] r_sum;
    logic [7:0]       r_lum;

    logic             w_free1, w_free2, w_free3;
    logic [36:0]      w_lum_prod;
    logic [18:0]      w_qr_p, w_qg_p, w_qb_p;
    logic [2:0]       w_qr, w_qg, w_qb;
    logic [7:0]       w_ansi, w_pal;

    assign w_free3 = !r_v3 || i_ready;
    assign w_free2 = !r_v2 || w_free3;
    assign w_free1 = !r_v1 || w_free2;
    assign o_ready = w_free1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_free1) begin
                r_v1 <= i_valid;
            end
            if (w_free2) begin
                r_v2 <= r_v1;
            end
            if (w_free3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign w_lum_prod = 37'(r_sum) * 37'(LUM_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_free1 && i_valid) begin
            r_s1 <= i_ctl;
        end
        if (w_free2 && r_v1) begin
            r_s2  <= r_s1;
            r_sum <= SUM_W'(r_s1.red)   * W_RED
                   + SUM_W'(r_s1.green) * W_GREEN
                   + SUM_W'(r_s1.blue)  * W_BLUE;
        end
        if (w_free3 && r_v2) begin
            r_s3  <= r_s2;
            r_lum <= w_lum_prod[LUM_SHIFT +: 8];
        end
    end

    // Colour cube steps
    always_comb begin
        w_qr_p = 19'(r_s3.red)   * CUBE_RECIP;
        w_qg_p = 19'(r_s3.green) * CUBE_RECIP;
        w_qb_p = 19'(r_s3.blue)  * CUBE_RECIP;
        w_qr   = w_qr_p[18:16];
        w_qg   = w_qg_p[18:16];
        w_qb   = w_qb_p[18:16];
        w_pal  = 8'(CUBE_BASE + 36 * int'(w_qr) + 6 * int'(w_qg) + int'(w_qb));
    end

    // Sixteen-colour pick: dark, then the strictly dominant channel, else white
    always_comb begin
        if (r_lum < DARK_LIMIT) begin
            w_ansi = SGR_BLACK;
        end else if (r_s3.red > r_s3.green && r_s3.red > r_s3.blue) begin
            w_ansi = (r_s3.red > BRIGHT_LIMIT) ? SGR_BR_RED : SGR_RED;
        end else if (r_s3.green > r_s3.red && r_s3.green > r_s3.blue) begin
            w_ansi = (r_s3.green > BRIGHT_LIMIT) ? SGR_BR_GREEN : SGR_GREEN;
        end else if (r_s3.blue > r_s3.red && r_s3.blue > r_s3.green) begin
            w_ansi = (r_s3.blue > BRIGHT_LIMIT) ? SGR_BR_BLUE : SGR_BLUE;
        end else begin
            w_ansi = SGR_WHITE;
        end
    end

    always_comb begin
        o_set.home      = r_s3.home;
        o_set.glyph_en  = r_s3.glyph_en;
        o_set.newline   = r_s3.newline;
        o_set.frame_end = r_s3.frame_end;
        o_set.glyph     = GLYPH_TAB[r_lum];
        o_set.cmd       = r_s3.cmd;
        o_set.code      = '0;
        o_set.red       = '0;
        o_set.green     = '0;
        o_set.blue      = '0;
        case (r_s3.cmd)
            CMD_ANSI:    o_set.code = w_ansi;
            CMD_PALETTE: o_set.code = w_pal;
            CMD_TRUE: begin
                o_set.red   = r_s3.red;
                o_set.green = r_s3.green;
                o_set.blue  = r_s3.blue;
            end
            default: ;
        endcase
    end

endmodule

/* rtl/pta_emit.sv */
// Result buffer: holds one pixel's result set and sends it out one beat at a time.
// Depends on pta_pkg and pta_stream_if.
module pta_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pta_pkg::t_res_set i_set,
    pta_stream_if.source      o_res
);
    import pta_pkg::*;

    // Pending bits: home, glyph, newline, colour reset, sent in that order
    logic [3:0] r_pend, n_pend;
    t_res_set   r_set;

    logic       w_fire, w_last;
    logic [3:0] w_low;
    t_glyph_out w_out;

    assign w_fire  = o_res.valid && o_res.ready;
    assign w_low   = r_pend & (~r_pend + 4'd1);
    assign w_last  = (r_pend & (r_pend - 4'd1)) == 4'd0;
    assign o_ready = (r_pend == 4'd0) || (w_fire && w_last);

    always_comb begin
        n_pend = r_pend;
        if (i_valid && o_ready) begin
            n_pend = {i_set.frame_end, i_set.newline, i_set.glyph_en, i_set.home};
        end else if (w_fire) begin
            n_pend = r_pend & ~w_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 4'd0;
        end else begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_set <= i_set;
        end
    end

    always_comb begin
        w_out          = '0;
        w_out.run_last = w_last;
        if (r_pend[0]) begin
            w_out.item_kind = KIND_HOME;
        end else if (r_pend[1]) begin
            w_out.item_kind     = KIND_GLYPH;
            w_out.glyph         = r_set.glyph;
            w_out.color_command = r_set.cmd;
            w_out.palette_code  = r_set.code;
            w_out.red_out       = r_set.red;
            w_out.green_out     = r_set.green;
            w_out.blue_out      = r_set.blue;
        end else if (r_pend[2]) begin
            w_out.item_kind = KIND_NEWLINE;
        end else begin
            w_out.item_kind = KIND_RESET;
        end
    end

    assign o_res.valid = r_pend != 4'd0;
    assign o_res.data  = w_out;

`ifndef SYNTH
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> $stable(r_pend))
        else $error("pending results changed while output stalled");

    a_drain_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_last && !i_valid |=> !o_res.valid)
        else $error("output still valid after last beat of a pixel");

    a_reset_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.item_kind == KIND_RESET |-> o_res.data.run_last)
        else $error("colour reset beat not marked as last");

    a_home_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && o_res.data.item_kind == KIND_HOME && !o_res.data.run_last
        |=> o_res.valid && o_res.data.item_kind != KIND_HOME)
        else $error("cursor home repeated within one pixel");
`endif

endmodule

/* rtl/pixel_to_ansi_ascii_glyph.sv */
// Pixel-to-glyph terminal renderer: one packed pixel in, up to four result beats out.
// The first beat of a pixel reaches o_res through the three luminance stages and then the result buffer.
// Throughput: one pixel per cycle while each yields at most one beat and o_res is ready; a pixel
// with more beats holds the single-pixel result buffer until its last beat is sent, so the output port sets the pace.
// Reset (synchronous, active low): registers to defaults, position and colour history
// cleared, pipeline and result buffer emptied.
module pixel_to_ansi_ascii_glyph #(
    parameter int MAX_DIMENSION = pta_pkg::MAX_DIMENSION_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pta_stream_if.sink                     i_pix,
    pta_stream_if.source                   o_res,
    input  logic                           i_cfg_we,
    input  logic [pta_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pta_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pta_pkg::*;

    // Configuration registers; the user must write them only while the block is idle, which the block does not enforce
    logic [1:0]            r_mode;
    logic [CFG_DATA_W-1:0] r_frame_width;
    logic [CFG_DATA_W-1:0] r_frame_height;
    logic [CFG_DATA_W-1:0] r_vis_cols;
    logic [CFG_DATA_W-1:0] r_vis_rows;

    logic      w_accept;
    logic      w_lum_valid, w_emit_ready;
    t_stage    w_ctl;
    t_res_set  w_set;
    t_pixel_in w_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= RST_COLOR_MODE;
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_vis_cols     <= RST_VIS_COLS;
            r_vis_rows     <= RST_VIS_ROWS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COLOR_MODE:   r_mode         <= i_cfg_data[1:0];
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                REG_VIS_COLS:     r_vis_cols     <= i_cfg_data;
                REG_VIS_ROWS:     r_vis_rows     <= i_cfg_data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // A beat is taken when the first pipeline stage is free
    assign w_pix    = i_pix.data;
    assign w_accept = i_pix.valid && i_pix.ready;

    // Position, visibility and truecolour decisions are made as the beat is taken
    pta_track #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_rgb          (w_pix.pixel_word[23:0]),
        .i_mode         (r_mode),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_vis_cols     (r_vis_cols),
        .i_vis_rows     (r_vis_rows),
        .o_ctl          (w_ctl)
    );

    // Luminance, glyph and colour code over three register stages
    pta_lum u_lum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_ctl   (w_ctl),
        .o_valid (w_lum_valid),
        .i_ready (w_emit_ready),
        .o_set   (w_set)
    );

    // Hold one pixel's result set and send it beat by beat
    pta_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_lum_valid),
        .o_ready (w_emit_ready),
        .i_set   (w_set),
        .o_res   (o_res)
    );

endmodule
